### src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/fmv_pkg.sv
// ----------------------------------------------------------------------------
// fmv_pkg
// Shared codes, types and the operator pass schedule of the FM voice.
// ----------------------------------------------------------------------------
package fmv_pkg;

  localparam int STEP_BITS  = 23;
  localparam int DEPTH_BITS = 16;
  localparam int AMP_BITS   = 16;
  localparam int DEPTH_FRAC = 12;
  localparam int CFG_IDX_BITS = 3;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [1:0] ALG_PARALLEL = 2'd0;
  localparam logic [1:0] ALG_SERIAL   = 2'd1;
  localparam logic [1:0] ALG_FEEDBACK = 2'd2;
  localparam logic [1:0] ALG_FB_ALIAS = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ALGORITHM = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CAR_STEP  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_M1_STEP   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_M2_STEP   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_M3_STEP   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_M1_DEPTH  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_M2_DEPTH  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_M3_DEPTH  = 3'd7;

  // offset source for a pass
  localparam logic [1:0] OFF_ZERO  = 2'd0;
  localparam logic [1:0] OFF_CHAIN = 2'd1;
  localparam logic [1:0] OFF_ACC   = 2'd2;

  // operator numbers, also phase memory addresses
  localparam logic [1:0] OP_CAR = 2'd0;
  localparam logic [1:0] OP_M1  = 2'd1;
  localparam logic [1:0] OP_M2  = 2'd2;
  localparam logic [1:0] OP_M3  = 2'd3;

  typedef struct packed {
    logic [1:0] op;       // operator read and written
    logic [1:0] off_src;  // offset added to its phase
    logic       wr;       // write back the advanced phase
    logic [1:0] dsel;     // depth register (operator number)
    logic [1:0] msel;     // step used as scale (operator number)
    logic       to_acc;   // term goes to the sum, else to the chain offset
    logic       last;     // carrier follows
  } pass_t;

  function automatic pass_t pass_desc(input logic [1:0] alg, input logic [1:0] idx);
    pass_t p;
    p = '{op: OP_M1, off_src: OFF_ZERO, wr: 1'b1, dsel: OP_M1, msel: OP_CAR,
          to_acc: 1'b1, last: 1'b0};
    case (alg)
      ALG_PARALLEL: begin
        p.op = (idx == 2'd0) ? OP_M1 : (idx == 2'd1) ? OP_M2 : OP_M3;
        p.dsel = p.op;
        p.last = (idx >= 2'd2);
      end
      ALG_SERIAL: begin
        case (idx)
          2'd0: p = '{OP_M3, OFF_ZERO, 1'b1, OP_M3, OP_M2, 1'b0, 1'b0};
          2'd1: p = '{OP_M2, OFF_CHAIN, 1'b1, OP_M2, OP_M1, 1'b0, 1'b0};
          default: p = '{OP_M1, OFF_CHAIN, 1'b1, OP_M1, OP_CAR, 1'b1, 1'b1};
        endcase
      end
      default: begin
        case (idx)
          2'd0: p = '{OP_M1, OFF_ZERO, 1'b0, OP_M1, OP_M1, 1'b0, 1'b0};
          2'd1: p = '{OP_M1, OFF_CHAIN, 1'b1, OP_M1, OP_CAR, 1'b1, 1'b0};
          2'd2: p = '{OP_M2, OFF_ZERO, 1'b1, OP_M2, OP_CAR, 1'b1, 1'b0};
          default: p = '{OP_M3, OFF_ZERO, 1'b1, OP_M3, OP_CAR, 1'b1, 1'b1};
        endcase
      end
    endcase
    return p;
  endfunction

endpackage

### src/fmv_phase_mem.sv
// ----------------------------------------------------------------------------
// fmv_phase_mem
// Four-entry phase store, one write and one registered read per cycle.
// Unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module fmv_phase_mem #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         we,
  input  logic [1:0]   waddr,
  input  logic [W-1:0] wdata,
  input  logic [1:0]   raddr,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem [4];
  logic [3:0]   valid_r;
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
  end

  assign rdata = rdata_r;
endmodule

### src/fmv_sine_rom.sv
// ----------------------------------------------------------------------------
// fmv_sine_rom
// Quarter-wave sine table with registered read, built at elaboration
// from a Q2.30 Taylor series.
// ----------------------------------------------------------------------------
module fmv_sine_rom #(
  parameter int SA = 10,
  parameter int SB = 16
) (
  input  logic          clk,
  input  logic [SA:0]   addr,
  output logic [SB-2:0] data
);
  import fmv_pkg::*;

  localparam int QSIZE = 1 << SA;
  localparam longint unsigned AMP = (64'd1 << (SB - 1)) - 64'd1;

  typedef logic [SB-2:0] tab_t [0:QSIZE];

  // shift-and-subtract quotient, evaluated at elaboration only
  function automatic longint unsigned cdiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    longint unsigned x, x2, term, sum, v;
    for (int i = 0; i <= QSIZE; i++) begin
      x = (HALF_PI_Q30 * longint'(i)) >> SA;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 8; k++) begin
        term = cdiv((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
        if (k % 2 == 1) sum = (sum >= term) ? sum - term : 64'd0;
        else sum = sum + term;
      end
      v = (sum * AMP + (64'd1 << 29)) >> 30;
      if (v > AMP) v = AMP;
      t[i] = v[SB-2:0];
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [SB-2:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= TAB[addr];
  end

  assign data = data_r;
endmodule

### src/fm_four_operator_voice_core.sv
// From input beat to result valid: three operator passes (algorithms 0 and
// 1) or four (feedback) through read, phase, sine, multiply and accumulate,
// then a carrier pass through read, phase, sine and output.
// Beats are accepted only when idle, one at a time through the single shared
// phase-memory read, sine-table read and two-stage multiply loop.
// Reset: synchronous, active low; state and config clear, phases read as zero.
// ----------------------------------------------------------------------------
// fm_four_operator_voice_core
// Four-operator FM voice: phases in a small memory, one sine lookup per pass
// and one scaled modulation term per modulator pass, signed output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fm_four_operator_voice_core #(
  parameter int PHASE_BITS     = 24,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fmv_pkg::AMP_BITS-1:0]       in_amplitude,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample,
  input  logic                               cfg_we,
  input  logic [fmv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fmv_pkg::STEP_BITS-1:0]      cfg_data
);
  import fmv_pkg::*;

  localparam int PB  = PHASE_BITS;
  localparam int SA  = SINE_ADDR_BITS;
  localparam int SB  = SAMPLE_BITS;
  localparam int P1W = SB - 1 + DEPTH_BITS;
  localparam int P2W = P1W + STEP_BITS;
  localparam int SH  = SB - 1 + DEPTH_FRAC;
  localparam int TW  = P2W - SH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_PH   = 3'd2;
  localparam logic [2:0] ST_SN   = 3'd3;
  localparam logic [2:0] ST_M2   = 3'd4;
  localparam logic [2:0] ST_AC   = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [1:0]            alg_r;
  logic [STEP_BITS-1:0]  step_r [4];
  logic [DEPTH_BITS-1:0] depth_r [4];

  logic [2:0]            state_r;
  logic [1:0]            idx_r;
  logic                  carrier_r;
  logic [AMP_BITS-1:0]   amp_r;
  logic [PB-1:0]         acc_r, chain_r;
  logic                  sign_r;
  logic [P1W-1:0]        p1_r;
  logic [P2W-1:0]        p2_r;
  logic                  out_valid_r;
  logic [SB-1:0]         out_sample_r;

  pass_t                 desc;
  logic [1:0]            op;
  logic [PB-1:0]         off_in, ph, q, term;
  logic [SA-1:0]         idx;
  logic [SA:0]           rom_addr;
  logic [SB-2:0]         rom_data;
  logic                  mem_we;
  logic [PB-1:0]         mem_wdata;
  logic [TW-1:0]         tmag;
  logic [SB-2:0]         omag;

  assign desc = pass_desc(alg_r, idx_r);
  assign op   = carrier_r ? OP_CAR : desc.op;

  always_comb begin
    if (carrier_r) off_in = acc_r;
    else begin
      case (desc.off_src)
        OFF_CHAIN: off_in = chain_r;
        OFF_ACC:   off_in = acc_r;
        default:   off_in = '0;
      endcase
    end
  end

  assign q         = ph + off_in;
  assign idx       = q[PB-3 -: SA];
  assign rom_addr  = q[PB-2] ? ({1'b1, {SA{1'b0}}} - {1'b0, idx}) : {1'b0, idx};
  assign mem_we    = (state_r == ST_PH) && (carrier_r || desc.wr);
  assign mem_wdata = q + PB'(step_r[op]);

  assign tmag = TW'(p2_r >> SH);
  assign term = sign_r ? (PB'(0) - PB'(tmag)) : PB'(tmag);
  assign omag = p1_r[P1W-1:AMP_BITS];

  fmv_phase_mem #(.W(PB)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (op),
    .wdata (mem_wdata),
    .raddr (op),
    .rdata (ph)
  );

  fmv_sine_rom #(.SA(SA), .SB(SB)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r <= ALG_PARALLEL;
      for (int i = 0; i < 4; i++) begin
        step_r[i]  <= '0;
        depth_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALGORITHM: alg_r      <= cfg_data[1:0];
        CFG_CAR_STEP:  step_r[0]  <= cfg_data;
        CFG_M1_STEP:   step_r[1]  <= cfg_data;
        CFG_M2_STEP:   step_r[2]  <= cfg_data;
        CFG_M3_STEP:   step_r[3]  <= cfg_data;
        CFG_M1_DEPTH:  depth_r[1] <= cfg_data[DEPTH_BITS-1:0];
        CFG_M2_DEPTH:  depth_r[2] <= cfg_data[DEPTH_BITS-1:0];
        CFG_M3_DEPTH:  depth_r[3] <= cfg_data[DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      carrier_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            amp_r     <= in_amplitude;
            idx_r     <= '0;
            carrier_r <= 1'b0;
            acc_r     <= '0;
            chain_r   <= '0;
            state_r   <= ST_RD;
          end
        end
        ST_RD: state_r <= ST_PH;
        ST_PH: begin
          sign_r  <= q[PB-1];
          state_r <= ST_SN;
        end
        ST_SN: begin
          if (carrier_r) begin
            p1_r    <= P1W'(rom_data) * P1W'(amp_r);
            state_r <= ST_OUT;
          end else begin
            p1_r    <= P1W'(rom_data) * P1W'(depth_r[desc.dsel]);
            state_r <= ST_M2;
          end
        end
        ST_M2: begin
          p2_r    <= P2W'(p1_r) * P2W'(step_r[desc.msel]);
          state_r <= ST_AC;
        end
        ST_AC: begin
          if (desc.to_acc) acc_r <= acc_r + term;
          else chain_r <= term;
          if (desc.last) carrier_r <= 1'b1;
          else idx_r <= idx_r + 2'd1;
          state_r <= ST_RD;
        end
        ST_OUT: begin
          // hold until the output register is free; magnitude never exceeds
          // full scale, so no clamp is needed
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= sign_r ? (SB'(0) - {1'b0, omag}) : {1'b0, omag};
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `ASSERT_IMPL(a_write_in_phase_step, clk, rst_n, mem_we, state_r == ST_PH)
  `ASSERT_IMPL(a_result_from_carrier, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_OUT)
endmodule
